// ===== hdl/gse_pkg.sv =====
// Shared types and constants of the signed Golomb encoder.
`timescale 1ns / 1ps
`default_nettype none

package gse_pkg;

   localparam int DIVISOR_MAX_BITS = 24;
   localparam int UNARY_BITS       = 20;
   localparam int CODE_BITS        = 16;
   localparam int LEN_BITS         = 5;
   localparam int RSP_FIELD_BITS   = UNARY_BITS + CODE_BITS + LEN_BITS;
   localparam int RSP_TDATA_BITS   = ((RSP_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_PAD_BITS     = RSP_TDATA_BITS - RSP_FIELD_BITS;
   localparam int DEFAULT_DIVISOR  = 10000;

   typedef struct packed {
      logic [DIVISOR_MAX_BITS-1:0] m;
      logic [DIVISOR_MAX_BITS-1:0] t;
      logic [LEN_BITS-1:0]         k;
   } cfg_type;

endpackage

`default_nettype wire

// ===== hdl/gse_csr.sv =====
// Divisor register with the derived code length and truncation threshold.
`timescale 1ns / 1ps
`default_nettype none

module gse_csr #(
   parameter int DIVISOR_BITS = 16
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     csr_valid,
   output logic                    csr_ready,
   input  wire  [DIVISOR_BITS-1:0] csr_data,
   output gse_pkg::cfg_type        cfg
);

   localparam logic [DIVISOR_BITS-1:0] RESET_DIVISOR =
      DIVISOR_BITS'(gse_pkg::DEFAULT_DIVISOR);

   function automatic gse_pkg::cfg_type derive(
      input logic [gse_pkg::DIVISOR_MAX_BITS-1:0] value
   );
      gse_pkg::cfg_type                       c;
      logic [gse_pkg::DIVISOR_MAX_BITS-1:0]   m;
      logic [gse_pkg::DIVISOR_MAX_BITS-1:0]   mm1;
      logic [gse_pkg::LEN_BITS-1:0]           k;
      logic [gse_pkg::DIVISOR_MAX_BITS:0]     pow;
      m   = (value == '0) ? gse_pkg::DIVISOR_MAX_BITS'(1) : value;
      mm1 = m - gse_pkg::DIVISOR_MAX_BITS'(1);
      k   = '0;
      for (int i = 0; i < gse_pkg::DIVISOR_MAX_BITS; i++) begin
         if (mm1[i]) begin
            k = gse_pkg::LEN_BITS'(i + 1);
         end
      end
      pow = (gse_pkg::DIVISOR_MAX_BITS + 1)'(1) << k;
      c.m = m;
      c.k = k;
      c.t = gse_pkg::DIVISOR_MAX_BITS'(pow - {1'b0, m});
      return c;
   endfunction

   gse_pkg::cfg_type cfg_ff;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= derive(gse_pkg::DIVISOR_MAX_BITS'(RESET_DIVISOR));
      end else if (csr_valid) begin
         cfg_ff <= derive(gse_pkg::DIVISOR_MAX_BITS'(csr_data));
      end
   end

`ifndef SYNTHESIS
   a_cfg_consistent: assert property (@(posedge clock) disable iff (reset)
      (cfg_ff.m != '0) && (cfg_ff.t < cfg_ff.m))
      else $error("divisor register holds an inconsistent threshold");
`endif

endmodule

`default_nettype wire

// ===== hdl/gse_div_pipe.sv =====
// Zigzag mapping stage followed by a pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none

module gse_div_pipe #(
   parameter int RESIDUAL_BITS = 20,
   parameter int DIVISOR_BITS  = 16
) (
   input  wire                      clock,
   input  wire                      reset,
   input  gse_pkg::cfg_type         cfg,
   input  wire                      in_valid,
   output logic                     in_ready,
   input  wire  [RESIDUAL_BITS-1:0] in_residual,
   output logic                     out_valid,
   input  wire                      out_ready,
   output logic [RESIDUAL_BITS-1:0] out_quot,
   output logic [DIVISOR_BITS-1:0]  out_rem
);

   logic [DIVISOR_BITS-1:0]  m;
   logic [RESIDUAL_BITS+1:0] stage_ready;
   logic [RESIDUAL_BITS:0]   valid_ff;
   logic [RESIDUAL_BITS-1:0] quot_ff [0:RESIDUAL_BITS];
   logic [DIVISOR_BITS-1:0]  rem_ff  [0:RESIDUAL_BITS];
   logic [RESIDUAL_BITS-1:0] quot_in [0:RESIDUAL_BITS];
   logic [DIVISOR_BITS-1:0]  rem_in  [0:RESIDUAL_BITS];

   assign m                           = cfg.m[DIVISOR_BITS-1:0];
   assign stage_ready[RESIDUAL_BITS+1] = out_ready;
   assign in_ready                    = stage_ready[0];
   assign out_valid                   = valid_ff[RESIDUAL_BITS];
   assign out_quot                    = quot_ff[RESIDUAL_BITS];
   assign out_rem                     = rem_ff[RESIDUAL_BITS];

   assign quot_in[0] = {in_residual[RESIDUAL_BITS-2:0], 1'b0}
                       ^ {RESIDUAL_BITS{in_residual[RESIDUAL_BITS-1]}};
   assign rem_in[0]  = '0;

   for (genvar s = 0; s <= RESIDUAL_BITS; s++) begin : g_stage
      assign stage_ready[s] = !valid_ff[s] || stage_ready[s+1];

      if (s > 0) begin : g_step
         logic [DIVISOR_BITS:0] trial;
         logic                  fits;
         always_comb begin
            trial      = {rem_ff[s-1], quot_ff[s-1][RESIDUAL_BITS-1]};
            fits       = trial >= {1'b0, m};
            rem_in[s]  = fits ? DIVISOR_BITS'(trial - {1'b0, m})
                              : trial[DIVISOR_BITS-1:0];
            quot_in[s] = {quot_ff[s-1][RESIDUAL_BITS-2:0], fits};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (stage_ready[s]) begin
            valid_ff[s] <= (s == 0) ? in_valid : valid_ff[(s == 0) ? 0 : s-1];
         end
      end

      always_ff @(posedge clock) begin
         if (stage_ready[s]) begin
            quot_ff[s] <= quot_in[s];
            rem_ff[s]  <= rem_in[s];
         end
      end
   end

`ifndef SYNTHESIS
   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> (out_rem < m))
      else $error("divider remainder is not below the divisor");
`endif

endmodule

`default_nettype wire

// ===== hdl/gse_code_stage.sv =====
// Truncated-binary remainder coding and the result output register.
`timescale 1ns / 1ps
`default_nettype none

module gse_code_stage #(
   parameter int RESIDUAL_BITS = 20,
   parameter int DIVISOR_BITS  = 16
) (
   input  wire                                clock,
   input  wire                                reset,
   input  gse_pkg::cfg_type                   cfg,
   input  wire                                in_valid,
   output logic                               in_ready,
   input  wire  [RESIDUAL_BITS-1:0]           in_quot,
   input  wire  [DIVISOR_BITS-1:0]            in_rem,
   output logic                               out_valid,
   input  wire                                out_ready,
   output logic [gse_pkg::UNARY_BITS-1:0]     out_unary_count,
   output logic [gse_pkg::CODE_BITS-1:0]      out_remainder_code,
   output logic [gse_pkg::LEN_BITS-1:0]       out_remainder_length
);

   logic [DIVISOR_BITS-1:0]           t;
   logic [gse_pkg::LEN_BITS-1:0]      k;
   logic                              below;
   logic [DIVISOR_BITS-1:0]           code_full;
   logic                              valid_ff;
   logic [gse_pkg::UNARY_BITS-1:0]    unary_ff;
   logic [gse_pkg::CODE_BITS-1:0]     code_ff;
   logic [gse_pkg::LEN_BITS-1:0]      len_ff;
   logic [gse_pkg::UNARY_BITS-1:0]    unary_in;
   logic [gse_pkg::CODE_BITS-1:0]     code_in;
   logic [gse_pkg::LEN_BITS-1:0]      len_in;

   assign t = cfg.t[DIVISOR_BITS-1:0];
   assign k = cfg.k;

   always_comb begin
      below     = in_rem < t;
      code_full = below ? in_rem : DIVISOR_BITS'(in_rem + t);
      len_in    = below ? gse_pkg::LEN_BITS'(k - gse_pkg::LEN_BITS'(1)) : k;
      code_in   = gse_pkg::CODE_BITS'(code_full);
      unary_in  = gse_pkg::UNARY_BITS'(in_quot);
   end

   assign in_ready             = !valid_ff || out_ready;
   assign out_valid            = valid_ff;
   assign out_unary_count      = unary_ff;
   assign out_remainder_code   = code_ff;
   assign out_remainder_length = len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         unary_ff <= unary_in;
         code_ff  <= code_in;
         len_ff   <= len_in;
      end
   end

`ifndef SYNTHESIS
   a_len_matches_k: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> ((len_ff == k) || ((len_ff + gse_pkg::LEN_BITS'(1)) == k)))
      else $error("remainder length is neither k nor k minus one");
   a_code_fits_len: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> ((code_ff >> len_ff) == '0))
      else $error("remainder code has bits above its length");
`endif

endmodule

`default_nettype wire

// ===== hdl/golomb_signed_encoder_unit.sv =====
// Top level of the signed Golomb encoder.
//
// Usage: each transfer on the req_ channel carries one signed residual in
// req_tdata. The block maps it to a non-negative value (n to 2n, negative n
// to 2|n|-1) and codes it with the divisor held in the csr_ register. Each
// residual gives exactly one transfer on the rsp_ channel with the unary
// quotient count, the truncated-binary remainder code and its bit length.
// The pipeline has one mapping stage, one restoring divider stage per quotient
// bit and one coding stage. Throughput is one residual per cycle while
// rsp_tready holds, set by the divider pipeline.
// The csr_ channel is always ready; write it only while no residual is in
// flight. A divisor of zero acts as one.
// Reset empties the pipeline and loads a divisor of 10000.
// When the receiver stalls, every stage holding a residual waits and empty
// stages keep filling, so nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none

module golomb_signed_encoder_unit #(
   parameter int RESIDUAL_BITS = 20,
   parameter int DIVISOR_BITS  = 16
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  csr_valid,
   output logic                                 csr_ready,
   input  wire  [DIVISOR_BITS-1:0]              csr_data,
   input  wire                                  req_tvalid,
   output logic                                 req_tready,
   // Fields from bit 0: residual, then zero fill.
   input  wire  [((RESIDUAL_BITS + 7) / 8) * 8 - 1:0] req_tdata,
   output logic                                 rsp_tvalid,
   input  wire                                  rsp_tready,
   // Fields from bit 0: unary_count, remainder_code, remainder_length, zero fill.
   output logic [gse_pkg::RSP_TDATA_BITS-1:0]   rsp_tdata
);

   gse_pkg::cfg_type                  cfg;
   logic                              div_valid;
   logic                              div_ready;
   logic [RESIDUAL_BITS-1:0]          div_quot;
   logic [DIVISOR_BITS-1:0]           div_rem;
   logic [gse_pkg::UNARY_BITS-1:0]    unary_count;
   logic [gse_pkg::CODE_BITS-1:0]     remainder_code;
   logic [gse_pkg::LEN_BITS-1:0]      remainder_length;

   gse_csr #(
      .DIVISOR_BITS (DIVISOR_BITS)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   gse_div_pipe #(
      .RESIDUAL_BITS (RESIDUAL_BITS),
      .DIVISOR_BITS  (DIVISOR_BITS)
   ) u_div_pipe (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .in_residual (req_tdata[RESIDUAL_BITS-1:0]),
      .out_valid   (div_valid),
      .out_ready   (div_ready),
      .out_quot    (div_quot),
      .out_rem     (div_rem)
   );

   gse_code_stage #(
      .RESIDUAL_BITS (RESIDUAL_BITS),
      .DIVISOR_BITS  (DIVISOR_BITS)
   ) u_code_stage (
      .clock                (clock),
      .reset                (reset),
      .cfg                  (cfg),
      .in_valid             (div_valid),
      .in_ready             (div_ready),
      .in_quot              (div_quot),
      .in_rem               (div_rem),
      .out_valid            (rsp_tvalid),
      .out_ready            (rsp_tready),
      .out_unary_count      (unary_count),
      .out_remainder_code   (remainder_code),
      .out_remainder_length (remainder_length)
   );

   assign rsp_tdata = {{gse_pkg::RSP_PAD_BITS{1'b0}}, remainder_length,
                       remainder_code, unary_count};

endmodule

`default_nettype wire

// ===== verif/golomb_signed_encoder_unit_tb.sv =====
// Self-checking testbench of the signed Golomb encoder with a divisor sweep and random flow control.
`timescale 1ns / 1ps

module golomb_signed_encoder_unit_tb;

   localparam int RES_BITS      = 20;
   localparam int DIV_BITS      = 16;
   localparam int REQ_BITS      = ((RES_BITS + 7) / 8) * 8;
   localparam int LIMIT_CYCLES  = 200000;
   localparam int LONG_HOLD     = 300;
   localparam int SETTLE_CYCLES = 40;
   localparam int SB_DEPTH      = 256;

   typedef struct packed {
      logic [gse_pkg::LEN_BITS-1:0]   len;
      logic [gse_pkg::CODE_BITS-1:0]  code;
      logic [gse_pkg::UNARY_BITS-1:0] unary;
   } golomb_code_type;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               csr_valid = 1'b0;
   logic                               csr_ready;
   logic [DIV_BITS-1:0]                csr_data = '0;
   logic                               req_tvalid = 1'b0;
   logic                               req_tready;
   logic [REQ_BITS-1:0]                req_tdata = '0;
   logic                               rsp_tvalid;
   logic                               rsp_tready = 1'b0;
   logic [gse_pkg::RSP_TDATA_BITS-1:0] rsp_tdata;

   golomb_code_type     expected_codes [0:SB_DEPTH-1];
   int                  expected_head = 0;
   int                  expected_tail = 0;
   logic [DIV_BITS-1:0] divisor_now = DIV_BITS'(gse_pkg::DEFAULT_DIVISOR);
   int                  sender_idle_pct = 0;
   int                  receiver_stall_pct = 0;
   int                  hold_requests = 0;
   int                  hold_taken = 0;
   int                  hold_left = 0;
   int                  error_count = 0;
   int                  cycle_count = 0;

   golomb_signed_encoder_unit #(
      .RESIDUAL_BITS(RES_BITS),
      .DIVISOR_BITS (DIV_BITS)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   always #5 clock = ~clock;

   function automatic golomb_code_type encode_residual(input logic [RES_BITS-1:0] residual,
                                                       input logic [DIV_BITS-1:0] divisor);
      longint unsigned m;
      longint unsigned raw;
      longint unsigned mapped;
      longint unsigned quotient;
      longint unsigned rem;
      longint unsigned span;
      int unsigned     k;
      golomb_code_type c;
      m = (divisor == 0) ? 64'd1 : 64'(divisor);
      k = 0;
      while ((64'd1 << k) < m) k++;
      raw = 64'(residual);
      if (residual[RES_BITS-1]) mapped = 2 * ((64'd1 << RES_BITS) - raw) - 1;
      else mapped = 2 * raw;
      quotient = mapped / m;
      rem = mapped % m;
      span = (64'd1 << k) - m;
      if (rem < span) begin
         c.len = gse_pkg::LEN_BITS'(k - 1);
         c.code = gse_pkg::CODE_BITS'(rem & ((64'd1 << (k - 1)) - 1));
      end else begin
         c.len = gse_pkg::LEN_BITS'(k);
         c.code = gse_pkg::CODE_BITS'((rem + span) & ((64'd1 << k) - 1));
      end
      c.unary = quotient[gse_pkg::UNARY_BITS-1:0];
      return c;
   endfunction

   function automatic logic [RES_BITS-1:0] pick_residual(input logic [DIV_BITS-1:0] divisor);
      int span;
      span = (divisor == 0) ? 4 : 4 * int'(divisor);
      case ($urandom_range(0, 4))
         0, 1: return RES_BITS'($urandom);
         2: return RES_BITS'($urandom_range(0, 600) - 300);
         3: return RES_BITS'(int'($urandom_range(0, 2 * span)) - span);
         default: begin
            case ($urandom_range(0, 3))
               0: return {1'b0, {(RES_BITS-1){1'b1}}};
               1: return {1'b1, {(RES_BITS-1){1'b0}}};
               2: return '1;
               default: return '0;
            endcase
         end
      endcase
   endfunction

   function automatic logic [DIV_BITS-1:0] pick_divisor();
      case ($urandom_range(0, 5))
         0: return DIV_BITS'($urandom_range(1, 16));
         1: return DIV_BITS'(1 << $urandom_range(0, DIV_BITS - 1));
         2: return DIV_BITS'($urandom_range(1, 65535));
         3: return '1;
         4: return '0;
         default: return DIV_BITS'($urandom_range(2, 300));
      endcase
   endfunction

   task automatic record_expected(input golomb_code_type code);
      expected_codes[expected_tail % SB_DEPTH] = code;
      expected_tail++;
   endtask

   task automatic send_residual(input logic [RES_BITS-1:0] residual);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {{(REQ_BITS-RES_BITS){1'b0}}, residual};
      do @(posedge clock); while (!req_tready);
      record_expected(encode_residual(residual, divisor_now));
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_tail != expected_head) @(posedge clock);
   endtask

   task automatic write_divisor(input logic [DIV_BITS-1:0] value);
      wait_drained();
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      divisor_now = value;
      @(posedge clock);
   endtask

   task automatic test_default_divisor();
      send_residual(20'sd0);
      send_residual(20'sd1);
      send_residual(-20'sd1);
      send_residual(20'sd3191);
      send_residual(20'sd3192);
      send_residual(-20'sd3192);
      send_residual(20'sd4999);
      send_residual(-20'sd5000);
      send_residual({1'b0, {(RES_BITS-1){1'b1}}});
      send_residual({1'b1, {(RES_BITS-1){1'b0}}});
   endtask

   task automatic test_divisor_extremes();
      write_divisor('0);
      send_residual({1'b1, {(RES_BITS-1){1'b0}}});
      send_residual(20'sd7);
      write_divisor(16'd1);
      send_residual({1'b1, {(RES_BITS-1){1'b0}}});
      send_residual({1'b0, {(RES_BITS-1){1'b1}}});
      write_divisor('1);
      send_residual(20'sd0);
      send_residual(-20'sd1);
      send_residual(20'sd32767);
      send_residual(-20'sd32768);
      write_divisor(16'd32769);
      send_residual(20'sd16383);
      send_residual(-20'sd16384);
      write_divisor(16'd3);
      send_residual(20'sd0);
      send_residual(-20'sd1);
   endtask

   task automatic test_backpressure();
      wait_drained();
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      hold_requests++;
      for (int i = 0; i < 80; i++) send_residual(pick_residual(divisor_now));
   endtask

   task automatic test_random_traffic(input int sender_pct, input int receiver_pct,
                                      input int item_count);
      wait_drained();
      sender_idle_pct = sender_pct;
      receiver_stall_pct = receiver_pct;
      for (int block = 0; block < 4; block++) begin
         write_divisor(pick_divisor());
         for (int i = 0; i < item_count / 4; i++) send_residual(pick_residual(divisor_now));
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_default_divisor();
      test_divisor_extremes();
      test_backpressure();
      test_random_traffic(0, 0, 188);
      test_random_traffic(75, 0, 188);
      test_random_traffic(0, 75, 188);
      test_random_traffic(16, 16, 188);
      write_divisor(16'd10000);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   always @(posedge clock) begin
      golomb_code_type want;
      golomb_code_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[gse_pkg::RSP_FIELD_BITS-1:0];
         if (expected_tail == expected_head) begin
            $display("%0t: unexpected transfer, expected none, got %h", $time, rsp_tdata);
            error_count++;
         end else begin
            want = expected_codes[expected_head % SB_DEPTH];
            expected_head++;
            if (got.unary !== want.unary) begin
               $display("%0t: unary_count expected %0d, got %0d", $time, want.unary, got.unary);
               error_count++;
            end
            if (got.code !== want.code) begin
               $display("%0t: remainder_code expected %h, got %h", $time, want.code, got.code);
               error_count++;
            end
            if (got.len !== want.len) begin
               $display("%0t: remainder_length expected %0d, got %0d", $time, want.len,
                        got.len);
               error_count++;
            end
            if (rsp_tdata[gse_pkg::RSP_TDATA_BITS-1:gse_pkg::RSP_FIELD_BITS] !== '0) begin
               $display("%0t: fill bits expected 0, got %h", $time,
                        rsp_tdata[gse_pkg::RSP_TDATA_BITS-1:gse_pkg::RSP_FIELD_BITS]);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (hold_taken != hold_requests) begin
         hold_taken <= hold_requests;
         hold_left <= LONG_HOLD;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("TEST FAILED");
         $finish;
      end
   end

endmodule

// ===== filelist.f =====
hdl/gse_pkg.sv
hdl/gse_csr.sv
hdl/gse_div_pipe.sv
hdl/gse_code_stage.sv
hdl/golomb_signed_encoder_unit.sv
verif/golomb_signed_encoder_unit_tb.sv
